// ===== hdl/frustum_box_point_cull_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the frustum box and point culling core
// Shorthand for clocked implication checks with a synchronous active-low
// reset, written out as labelled concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_POINT_CULL_CORE_ASSERT_SVH
`define FRUSTUM_BOX_POINT_CULL_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define FBPC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define FBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fbpc_pkg.sv =====
// ---------------------------------------------------------------------------
// fbpc_pkg
// Shared constants and types of the frustum box and point culling core.
// ---------------------------------------------------------------------------
package fbpc_pkg;

    localparam int NUM_PLANES     = 6;
    localparam int BOX_CORNERS    = 8;
    localparam int CORNER_IDX_W   = $clog2(BOX_CORNERS);
    localparam int COORD_BITS_DEF = 16;
    localparam int PLANE_W        = 64;
    localparam int COEF_W         = 16;
    localparam int FRAC_BITS      = 14;
    // Width of the signed constant term d * 2^14.
    localparam int D_TERM_W       = COEF_W + FRAC_BITS;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [CORNER_IDX_W-1:0] LAST_CORNER = CORNER_IDX_W'(BOX_CORNERS - 1);

    // Control part of the word handed from cell to cell.
    // flag: for a point, "positive on every plane so far";
    //       for a box, "some plane has all corners behind it so far".
    typedef struct packed {
        logic valid;
        logic is_point;
        logic last;
        logic flag;
    } t_chain_ctl;

endpackage

// ===== hdl/frustum_box_point_cull_core.sv =====
// ---------------------------------------------------------------------------
// frustum_box_point_cull_core
// View-frustum culling of axis-aligned boxes and single points against six
// configured planes, built as a chain of six plane cells.
// ---------------------------------------------------------------------------
// Usage:
// Input words arrive on the s_axis channel. tuser is the kind: 0 for a box
// corner, 1 for a point test. A box is sent as eight corner words in a row;
// point words may be mixed in between without disturbing the box. Output
// words leave on the m_axis channel: tdata bit 0 is visible, tuser is
// from_point. Corners one to seven give no output word; the eighth corner
// and every point give exactly one.
// Planes are loaded through the write port (index 0 left, 1 right, 2 top,
// 3 bottom, 4 far, 5 near); indexes 6 and 7 are ignored. Write only while
// the core is idle.
// Each word passes an entry register, two stages in each of the six plane
// cells and the output register. One word is accepted every cycle while the
// receiver keeps up; the three multipliers of each cell are pipelined, so
// nothing in the chain iterates.
// Reset clears the planes to zero and starts a fresh box. When the receiver
// holds tready low with a result waiting, the whole chain freezes and
// s_axis tready drops in the same cycle; no word is lost or repeated.
// ---------------------------------------------------------------------------
`include "frustum_box_point_cull_core_assert.svh"

module frustum_box_point_cull_core
    import fbpc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x, pos_y, pos_z, shift_x, shift_y, shift_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // kind
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // visible, zero fill
    output logic [7:0]            o_m_axis_tdata,
    // from_point
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PLANE_W-1:0]    i_cfg_data
);

    // Coordinates inside the chain carry one extra bit for position + offset.
    localparam int CW = COORD_BITS + 1;

    logic w_en;
    logic w_accept;
    logic w_kind;

    logic signed [COORD_BITS-1:0] w_pos_x, w_pos_y, w_pos_z;
    logic signed [COORD_BITS-1:0] w_shift_x, w_shift_y, w_shift_z;

    logic [CORNER_IDX_W-1:0] r_corner_index;

    t_chain_ctl           n_in_ctl;
    logic signed [CW-1:0] n_in_x, n_in_y, n_in_z;

    t_chain_ctl           w_ctl [0:NUM_PLANES];
    logic signed [CW-1:0] w_x   [0:NUM_PLANES];
    logic signed [CW-1:0] w_y   [0:NUM_PLANES];
    logic signed [CW-1:0] w_z   [0:NUM_PLANES];

    logic w_cfg_sel [0:NUM_PLANES-1];

    logic r_out_valid;
    logic r_out_visible;
    logic r_out_from_point;

    // The whole chain moves together unless a result is held by the receiver.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid && w_en;
    assign w_kind          = i_s_axis_tuser;

    assign w_pos_x   = i_s_axis_tdata[COORD_BITS-1:0];
    assign w_pos_y   = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_pos_z   = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_shift_x = i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign w_shift_y = i_s_axis_tdata[5*COORD_BITS-1:4*COORD_BITS];
    assign w_shift_z = i_s_axis_tdata[6*COORD_BITS-1:5*COORD_BITS];

    // Corner counting happens at the entry, so each word carries its own
    // end-of-box mark through the chain. Points leave the count alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_index <= '0;
        end else if (w_accept && !w_kind) begin
            r_corner_index <= (r_corner_index == LAST_CORNER) ? '0 :
                              r_corner_index + 1'b1;
        end
    end

    // Entry stage: a box corner gets its object offset added, a point is
    // taken as it is. Points start with flag set (inside until a plane says
    // otherwise); boxes start with flag clear (not culled yet).
    always_comb begin
        n_in_ctl.valid    = w_accept;
        n_in_ctl.is_point = w_kind;
        n_in_ctl.last     = !w_kind && (r_corner_index == LAST_CORNER);
        n_in_ctl.flag     = w_kind;
        if (w_kind) begin
            n_in_x = CW'(w_pos_x);
            n_in_y = CW'(w_pos_y);
            n_in_z = CW'(w_pos_z);
        end else begin
            n_in_x = CW'(w_pos_x) + CW'(w_shift_x);
            n_in_y = CW'(w_pos_y) + CW'(w_shift_y);
            n_in_z = CW'(w_pos_z) + CW'(w_shift_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_ctl[0] <= '0;
        end else if (w_en) begin
            w_ctl[0] <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_x[0] <= n_in_x;
            w_y[0] <= n_in_y;
            w_z[0] <= n_in_z;
        end
    end

    // The row of plane cells, one per frustum plane in register order.
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
        assign w_cfg_sel[g] = i_cfg_we && (i_cfg_addr == CFG_ADDR_W'(g));

        fbpc_plane_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_cfg_we   (w_cfg_sel[g]),
            .i_cfg_data (i_cfg_data),
            .i_ctl      (w_ctl[g]),
            .i_x        (w_x[g]),
            .i_y        (w_y[g]),
            .i_z        (w_z[g]),
            .o_ctl      (w_ctl[g+1]),
            .o_x        (w_x[g+1]),
            .o_y        (w_y[g+1]),
            .o_z        (w_z[g+1])
        );
    end

    // Output register. At the tail a point's flag means inside on all planes;
    // a box's flag means some plane had every corner behind it, i.e. culled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctl[NUM_PLANES].valid &&
                           (w_ctl[NUM_PLANES].is_point || w_ctl[NUM_PLANES].last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_visible    <= w_ctl[NUM_PLANES].is_point ? w_ctl[NUM_PLANES].flag :
                                                             !w_ctl[NUM_PLANES].flag;
            r_out_from_point <= w_ctl[NUM_PLANES].is_point;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_visible};
    assign o_m_axis_tuser  = r_out_from_point;

    // A held result must freeze the input side.
    `FBPC_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input accepted while a result is held")
    // The eighth corner closes the box and restarts the count.
    `FBPC_ASSERT_NEXT(a_box_wraps, i_clk, i_rst_n, w_accept && !w_kind && (r_corner_index == LAST_CORNER), r_corner_index == '0, "corner count did not wrap after the eighth corner")
    // A point in mid-box leaves the pending box untouched.
    `FBPC_ASSERT_NEXT(a_point_keeps_count, i_clk, i_rst_n, w_accept && w_kind, $stable(r_corner_index), "point item changed the corner count")
    // Every point reaching the tail becomes a point result.
    `FBPC_ASSERT_NEXT(a_point_reaches_output, i_clk, i_rst_n, w_en && w_ctl[NUM_PLANES].valid && w_ctl[NUM_PLANES].is_point, r_out_valid && r_out_from_point, "point word at the tail gave no point result")

endmodule

// ===== hdl/fbpc_plane_cell.sv =====
// ---------------------------------------------------------------------------
// fbpc_plane_cell
// One plane of the frustum: holds the plane coefficients and the behind bit
// of the box in progress, evaluates a*x+b*y+c*z+d*2^14 over two stages and
// passes the word on to the next cell.
// ---------------------------------------------------------------------------
module fbpc_plane_cell
    import fbpc_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_cfg_we,
    input  logic [PLANE_W-1:0]    i_cfg_data,
    input  t_chain_ctl            i_ctl,
    input  logic signed [CW-1:0]  i_x,
    input  logic signed [CW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_z,
    output t_chain_ctl            o_ctl,
    output logic signed [CW-1:0]  o_x,
    output logic signed [CW-1:0]  o_y,
    output logic signed [CW-1:0]  o_z
);

    localparam int PW = COEF_W + CW;
    localparam int SW = ((PW > D_TERM_W) ? PW : D_TERM_W) + 2;

    logic [PLANE_W-1:0] r_plane;
    logic               r_behind;

    logic signed [COEF_W-1:0] w_a, w_b, w_c, w_d;

    t_chain_ctl               r_s1_ctl;
    logic signed [PW-1:0]     r_px, r_py, r_pz;
    logic signed [COEF_W-1:0] r_pd;
    logic signed [CW-1:0]     r_s1_x, r_s1_y, r_s1_z;

    logic signed [SW-1:0]     w_sum;
    logic                     w_pos;
    logic                     w_new_behind;
    t_chain_ctl               n_s2_ctl;

    t_chain_ctl               r_s2_ctl;
    logic signed [CW-1:0]     r_s2_x, r_s2_y, r_s2_z;

    assign w_a = r_plane[COEF_W-1:0];
    assign w_b = r_plane[2*COEF_W-1:COEF_W];
    assign w_c = r_plane[3*COEF_W-1:2*COEF_W];
    assign w_d = r_plane[4*COEF_W-1:3*COEF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we) begin
            r_plane <= i_cfg_data;
        end
    end

    // Stage one: the three products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= PW'(w_a) * PW'(i_x);
            r_py   <= PW'(w_b) * PW'(i_y);
            r_pz   <= PW'(w_c) * PW'(i_z);
            r_pd   <= w_d;
            r_s1_x <= i_x;
            r_s1_y <= i_y;
            r_s1_z <= i_z;
        end
    end

    // Stage two: sum, sign test and flag update.
    always_comb begin
        w_sum        = SW'(r_px) + SW'(r_py) + SW'(r_pz) + (SW'(r_pd) <<< FRAC_BITS);
        w_pos        = !w_sum[SW-1] && (w_sum != '0);
        w_new_behind = r_behind && !w_pos;
        n_s2_ctl     = r_s1_ctl;
        if (r_s1_ctl.is_point) begin
            n_s2_ctl.flag = r_s1_ctl.flag && w_pos;
        end else begin
            n_s2_ctl.flag = r_s1_ctl.flag || (r_s1_ctl.last && w_new_behind);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
            r_behind <= 1'b1;
        end else if (i_en) begin
            r_s2_ctl <= n_s2_ctl;
            if (r_s1_ctl.valid && !r_s1_ctl.is_point) begin
                r_behind <= r_s1_ctl.last ? 1'b1 : w_new_behind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_x <= r_s1_x;
            r_s2_y <= r_s1_y;
            r_s2_z <= r_s1_z;
        end
    end

    assign o_ctl = r_s2_ctl;
    assign o_x   = r_s2_x;
    assign o_y   = r_s2_y;
    assign o_z   = r_s2_z;

endmodule

// ===== test/frustum_box_point_cull_checker.sv =====
// ---------------------------------------------------------------------------
// Frustum culling checker
// Watches the input, output and plane-write ports of the culling core, keeps
// its own copy of the planes and of the box accumulation, predicts the result
// of every accepted point and every completed box and compares each output
// word against the oldest prediction.
// ---------------------------------------------------------------------------
package cull_tb_pkg;

    import fbpc_pkg::*;

    localparam int COORD_W = 16;

    typedef enum logic {
        KIND_CORNER = 1'b0,
        KIND_POINT  = 1'b1
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT,
        REG_RIGHT,
        REG_TOP,
        REG_BOTTOM,
        REG_FAR,
        REG_NEAR,
        REG_SPARE6,
        REG_SPARE7
    } t_plane_idx;

    // Input tdata layout, pos_x in the lowest bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] shift_z;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
    } t_coord_word;

endpackage

module cull_checker
    import fbpc_pkg::*;
    import cull_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [6*COORD_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [PLANE_W-1:0]    i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic visible;
        logic from_point;
    } t_verdict;

    logic [PLANE_W-1:0]    planes [NUM_PLANES];
    logic [NUM_PLANES-1:0] behind_mask;
    int                    corner_cnt;
    t_verdict              verdict_q [$];
    int                    fails;
    int                    checked;

    // Signed distance of a point from a plane, scaled by 2^14, computed exactly.
    function automatic longint plane_dist(logic [PLANE_W-1:0] pl, longint x, longint y,
                                          longint z);
        longint a, b, c, d;
        a = longint'($signed(pl[15:0]));
        b = longint'($signed(pl[31:16]));
        c = longint'($signed(pl[47:32]));
        d = longint'($signed(pl[63:48]));
        return a * x + b * y + c * z + d * (longint'(1) << FRAC_BITS);
    endfunction

    always @(posedge i_clk) begin : watch
        t_coord_word w;
        t_verdict    want;
        t_verdict    got;
        longint      x, y, z;
        logic        all_pos;
        if (!i_rst_n) begin
            foreach (planes[i]) planes[i] = '0;
            behind_mask = '1;
            corner_cnt  = 0;
            verdict_q.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.visible    = i_m_tdata[0];
                got.from_point = i_m_tuser;
                if (verdict_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: unexpected result visible=%0b from_point=%0b",
                                 got.visible, got.from_point);
                end else begin
                    want = verdict_q.pop_front();
                    checked++;
                    if (got.visible !== want.visible || got.from_point !== want.from_point) begin
                        fails++;
                        if (fails <= 10)
                            $display("checker: result %0d expected visible=%0b from_point=%0b, got visible=%0b from_point=%0b",
                                     checked, want.visible, want.from_point,
                                     got.visible, got.from_point);
                    end
                end
            end

            if (i_cfg_we && i_cfg_addr < NUM_PLANES)
                planes[i_cfg_addr] = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                w = t_coord_word'(i_s_tdata);
                x = longint'(w.pos_x);
                y = longint'(w.pos_y);
                z = longint'(w.pos_z);
                if (i_s_tuser == KIND_POINT) begin
                    // A point is answered at once and leaves the box alone.
                    all_pos = 1'b1;
                    for (int p = 0; p < NUM_PLANES; p++)
                        if (plane_dist(planes[p], x, y, z) <= 0)
                            all_pos = 1'b0;
                    verdict_q.push_back('{visible: all_pos, from_point: 1'b1});
                end else begin
                    x = x + longint'(w.shift_x);
                    y = y + longint'(w.shift_y);
                    z = z + longint'(w.shift_z);
                    for (int p = 0; p < NUM_PLANES; p++)
                        if (plane_dist(planes[p], x, y, z) > 0)
                            behind_mask[p] = 1'b0;
                    if (corner_cnt == BOX_CORNERS - 1) begin
                        verdict_q.push_back('{visible: (behind_mask == '0), from_point: 1'b0});
                        behind_mask = '1;
                        corner_cnt  = 0;
                    end else begin
                        corner_cnt++;
                    end
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== test/frustum_box_point_cull_core_tb.sv =====
// ---------------------------------------------------------------------------
// Frustum box and point culling core testbench
// Drives corner and point words into the core under several plane settings
// and idling patterns, while a checker beside the core predicts every result
// and compares it with what the core sends out.
// ---------------------------------------------------------------------------
module frustum_box_point_cull_core_tb;

    import fbpc_pkg::*;
    import cull_tb_pkg::*;

    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 85;
    // Margin for the core to answer after it accepts a word, before touching
    // the planes or ending the run.
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SPREAD         = 6000;

    typedef enum int {
        STYLE_AXIS,
        STYLE_EXTREME,
        STYLE_RANDOM,
        STYLE_SIGNS,
        STYLE_PARTIAL
    } t_plane_style;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [6*COORD_W-1:0]  s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_data;
    logic                  m_user;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [PLANE_W-1:0]    cfg_data;

    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    int fails;
    int pending;
    int checked;
    int corners_sent;
    int points_sent;
    int writes_done;
    int watchdog;

    always #2 clk = ~clk;

    frustum_box_point_cull_core #(
        .COORD_BITS(COORD_W)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data)
    );

    cull_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tuser   (m_user),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fails),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Packs one plane register: a in the lowest sixteen bits, then b, c and d.
    function automatic logic [PLANE_W-1:0] pack_plane(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic int rnd16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Mostly near the frustum so that results are mixed; now and then anything at all.
    function automatic int pick_coord(int spread);
        if ($urandom_range(9) == 0)
            return rnd16();
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    function automatic int pick_shift();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 0;
        if (r < 8)
            return pick_coord(SPREAD / 2);
        return rnd16();
    endfunction

    function automatic int extreme_field();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // A plane facing mostly along one axis, tilted a little, with the origin inside.
    // Even indexes face along the positive axis, odd ones along the negative axis.
    function automatic logic [PLANE_W-1:0] axis_plane(int idx);
        int cf [3];
        int lead;
        foreach (cf[k]) cf[k] = int'($urandom_range(8192)) - 4096;
        lead = $urandom_range(8192, 16383);
        cf[idx / 2] = (idx % 2) ? -lead : lead;
        return pack_plane(cf[0], cf[1], cf[2], $urandom_range(200, 3000));
    endfunction

    function automatic t_plane_style style_for(int phase);
        case (phase)
            1:       return STYLE_EXTREME;
            3:       return STYLE_RANDOM;
            5:       return STYLE_SIGNS;
            7:       return STYLE_PARTIAL;
            default: return STYLE_AXIS;
        endcase
    endfunction

    // One register write. The enable stays high for back-to-back writes and is
    // lowered only after the last one, so it never gets two updates in a step.
    task automatic cfg_write(t_plane_idx idx, logic [PLANE_W-1:0] value, bit last);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        writes_done++;
        if (last)
            cfg_we <= 1'b0;
    endtask

    // Offers one word and returns at the edge where it is taken. Idle cycles
    // before it carry junk on tdata, which the core must ignore.
    task automatic put_word(t_kind kind, int px, int py, int pz, int sx, int sy, int sz);
        t_coord_word w;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= {$urandom, $urandom, $urandom};
            @(posedge clk);
        end
        w.pos_x   = 16'(px);
        w.pos_y   = 16'(py);
        w.pos_z   = 16'(pz);
        w.shift_x = 16'(sx);
        w.shift_y = 16'(sy);
        w.shift_z = 16'(sz);
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= w;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        if (kind == KIND_POINT)
            points_sent++;
        else
            corners_sent++;
    endtask

    // Points carry random offset fields: the core must not use them.
    task automatic send_point(int px, int py, int pz);
        put_word(KIND_POINT, px, py, pz, rnd16(), rnd16(), rnd16());
    endtask

    // Corners first to last of the box spanned by the two corners, all with one offset.
    // Bit 0 of the corner number picks x, bit 1 y and bit 2 z.
    task automatic send_box(int x0, int y0, int z0, int x1, int y1, int z1,
                            int sx, int sy, int sz, int first, int last);
        for (int c = first; c <= last; c++)
            put_word(KIND_CORNER, (c & 1) ? x1 : x0, (c & 2) ? y1 : y0, (c & 4) ? z1 : z0,
                     sx, sy, sz);
    endtask

    // A well-formed box with random size and offset, now and then with a point
    // slipped in between its corners.
    task automatic random_box();
        int lo [3];
        int hi [3];
        int sh [3];
        for (int k = 0; k < 3; k++) begin
            lo[k] = pick_coord(SPREAD);
            hi[k] = lo[k] + int'($urandom_range(SPREAD / 2));
            if (hi[k] > 32767)
                hi[k] = 32767;
            sh[k] = pick_shift();
        end
        for (int c = 0; c < BOX_CORNERS; c++) begin
            if ($urandom_range(99) < 6)
                send_point(pick_coord(SPREAD), pick_coord(SPREAD), pick_coord(SPREAD));
            send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], sh[0], sh[1], sh[2], c, c);
        end
    endtask

    // A short burst of arbitrary words. Corners here break the box alignment,
    // which later boxes then inherit.
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 10);
        repeat (n)
            put_word($urandom_range(1) ? KIND_POINT : KIND_CORNER,
                     rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
    endtask

    // Waits until every predicted result has left the core, then lets the
    // pipeline run empty so that a box still part-way through it is settled too.
    // The first edge lets the checker see the last accepted word.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Loads a new set of planes, always finishing with a write to an unused index.
    task automatic set_planes(t_plane_style style);
        logic [PLANE_W-1:0] v;
        for (int i = 0; i < NUM_PLANES; i++) begin
            case (style)
                STYLE_EXTREME: v = pack_plane(extreme_field(), extreme_field(),
                                              extreme_field(), extreme_field());
                STYLE_RANDOM:  v = {$urandom, $urandom};
                STYLE_SIGNS:   v = (i % 2) ? '1 : '0;
                default:       v = axis_plane(i);
            endcase
            // In a partial reload about half of the planes keep their old value.
            if (style != STYLE_PARTIAL || $urandom_range(1))
                cfg_write(t_plane_idx'(i), v, 1'b0);
        end
        cfg_write($urandom_range(1) ? REG_SPARE7 : REG_SPARE6, {$urandom, $urandom}, 1'b1);
    endtask

    // The receiver: random stalls at the rate of the current phase, and on
    // request one long hold-off while the sender keeps offering words, so the
    // pipeline fills up and the core has to stall its input.
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Ends the run if no word moves on any port for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("frustum_box_point_cull_core_tb NOT OK");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    initial begin : stimulus
        int         target;
        int         r;
        t_idle_mode mode;
        rst_n        = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_data     = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        corners_sent = 0;
        points_sent  = 0;
        writes_done  = 0;
        watchdog     = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset every plane is zero, so every plane value is
        // exactly zero and a point counts as outside.
        send_point(0, 0, 0);
        s_valid <= 1'b0;
        drain();

        // An axis-aligned cube of half-width 1000 around the origin. The unused
        // indexes get all ones, which must not land on any real plane.
        cfg_write(REG_LEFT,   pack_plane(16384, 0, 0, 1000), 1'b0);
        cfg_write(REG_RIGHT,  pack_plane(-16384, 0, 0, 1000), 1'b0);
        cfg_write(REG_TOP,    pack_plane(0, -16384, 0, 1000), 1'b0);
        cfg_write(REG_BOTTOM, pack_plane(0, 16384, 0, 1000), 1'b0);
        cfg_write(REG_FAR,    pack_plane(0, 0, -16384, 1000), 1'b0);
        cfg_write(REG_NEAR,   pack_plane(0, 0, 16384, 1000), 1'b0);
        cfg_write(REG_SPARE6, '1, 1'b0);
        cfg_write(REG_SPARE7, '1, 1'b1);

        send_point(0, 0, 0);
        // Sits exactly on the right plane: a zero value means outside.
        send_point(1000, 0, 0);
        // A box pushed by its offset onto the right plane, so every corner is at
        // zero or behind it and the box is culled. A point with every field at
        // an extreme arrives half-way through and must not disturb the box.
        send_box(0, -10, -10, 10, 10, 10, 1000, 0, 0, 0, 3);
        put_word(KIND_POINT, -32768, -32768, -32768, 32767, 32767, 32767);
        send_box(0, -10, -10, 10, 10, 10, 1000, 0, 0, 4, 7);
        // Coordinates and offsets at their limits, giving sums well beyond the
        // coordinate range.
        send_box(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0, 0, 7);
        // Half a box behind the right plane, then the plane moves outwards
        // before the other half arrives; only the later corners see the new plane.
        send_box(2000, 0, 0, 2010, 10, 10, 0, 0, 0, 0, 3);
        s_valid <= 1'b0;
        drain();
        cfg_write(REG_RIGHT, pack_plane(-16384, 0, 0, 3000), 1'b1);
        send_box(2000, 0, 0, 2010, 10, 10, 0, 0, 0, 4, 7);

        // Random part: each phase loads a new plane set and idles in its own way.
        for (int ph = 0; ph < PHASES; ph++) begin
            s_valid <= 1'b0;
            drain();
            set_planes(style_for(ph));
            mode = t_idle_mode'(ph % 4);
            case (mode)
                IDLE_SENDER: begin
                    tx_idle_pct  = 71;
                    rx_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 71;
                end
                IDLE_BOTH: begin
                    tx_idle_pct  = 25;
                    rx_stall_pct = 25;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            if (mode == IDLE_NONE)
                hold_req = 1'b1;
            target = corners_sent + points_sent + PHASE_WORDS;
            while (corners_sent + points_sent < target) begin
                r = $urandom_range(99);
                if (r < 70)
                    random_box();
                else if (r < 85)
                    send_point(pick_coord(SPREAD), pick_coord(SPREAD), pick_coord(SPREAD));
                else
                    noise_burst();
            end
        end
        s_valid <= 1'b0;
        drain();

        $display("Covered %0d box corners and %0d points over %0d plane sets (%0d writes).",
                 corners_sent, points_sent, PHASES + 2, writes_done);
        $display("%0d results checked with no idling, either side idling and a long hold-off.",
                 checked);
        if (fails == 0 && pending == 0)
            $display("frustum_box_point_cull_core_tb OK");
        else
            $display("frustum_box_point_cull_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== frustum_box_point_cull_core.f =====
+incdir+hdl
hdl/fbpc_pkg.sv
hdl/fbpc_plane_cell.sv
hdl/frustum_box_point_cull_core.sv
test/frustum_box_point_cull_checker.sv
test/frustum_box_point_cull_core_tb.sv
